// ===== hdl/waveform_column_span_renderer_unit_assert.svh =====
// Assertion macros for the waveform column span renderer.
// Included by the top level; no other dependencies.
`ifndef WAVEFORM_COLUMN_SPAN_RENDERER_UNIT_ASSERT_SVH
`define WAVEFORM_COLUMN_SPAN_RENDERER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Consequent must hold in the same cycle as the antecedent
`define WCSR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Consequent must hold in the cycle after the antecedent
`define WCSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define WCSR_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define WCSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== hdl/wcsr_pkg.sv =====
// Shared constants for the waveform column span renderer: field widths,
// register indexes, draw mode codes and reset values. No dependencies.
package wcsr_pkg;

   localparam int MAX_HEIGHT_DEFAULT = 1024;
   localparam int MAX_WIDTH_DEFAULT  = 4096;

   // Fixed field widths
   localparam int SAMPLE_W   = 16;
   localparam int CHAN_W     = 3;
   localparam int MODE_W     = 2;
   localparam int HEIGHT_W   = 11;
   localparam int COLOR_W    = 24;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 24;

   // Smallest usable display height and the Q1.15 full-scale offset
   localparam int MIN_HEIGHT = 2;
   localparam int FULL_SCALE = 32768;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_DRAW_MODE  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HEIGHT     = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_EVEN_COLOR = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ODD_COLOR  = 2'd3;

   // Draw modes
   localparam logic [MODE_W-1:0] MODE_LINE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MIRROR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CENTRE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_BOTTOM = 2'd3;

   // Register reset values
   localparam logic [MODE_W-1:0]   MODE_RESET       = MODE_LINE;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET     = 11'd250;
   localparam logic [COLOR_W-1:0]  EVEN_COLOR_RESET = 24'hFF0000;
   localparam logic [COLOR_W-1:0]  ODD_COLOR_RESET  = 24'h0000FF;

endpackage

// ===== hdl/waveform_column_span_renderer_unit.sv =====
// Waveform column span renderer: maps one Q1.15 sample per display column to
// a span of rows and a colour. Depends on wcsr_pkg and the assertion header.
//
// One sample word is taken per clock cycle while the output is not stalled;
// its span word passes the input stage register, then the output register.
// The input stage registers the scaled row product (one 17 by 11 bit
// multiply). The result stage clamps it, picks the span for the draw mode and
// updates the previous row. An output register parts the two sides, so one
// more word is taken while a result waits. The result stage keeps the previous
// row, so line mode joins consecutive samples at full rate. The user must write
// registers only while the block is idle; the block does not enforce this.
`include "waveform_column_span_renderer_unit_assert.svh"

module waveform_column_span_renderer_unit #(
   parameter int MAX_HEIGHT = wcsr_pkg::MAX_HEIGHT_DEFAULT,
   parameter int MAX_WIDTH  = wcsr_pkg::MAX_WIDTH_DEFAULT,
   localparam int ROW_W  = $clog2(MAX_HEIGHT),
   localparam int COL_W  = $clog2(MAX_WIDTH),
   localparam int REQ_DW = ((wcsr_pkg::SAMPLE_W + COL_W + 7) / 8) * 8,
   localparam int RSP_DW = ((COL_W + 2 * ROW_W + wcsr_pkg::COLOR_W + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // sample input
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [REQ_DW-1:0]                 req_tdata,  // sample, column
   input  logic [wcsr_pkg::CHAN_W-1:0]       req_tuser,  // channel
   // span output
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [RSP_DW-1:0]                 rsp_tdata,  // out_column, row_low,
                                                         // row_high, pixel_color
   output logic                              rsp_tuser,  // span_valid
   // register write port
   input  logic                              csr_we,
   input  logic [wcsr_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [wcsr_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import wcsr_pkg::*;

   localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
   localparam int HCMP_W = (HGT_W > HEIGHT_W) ? HGT_W : HEIGHT_W;
   localparam int PROD_W = SAMPLE_W + 1 + HGT_W;

   typedef struct packed {
      logic [HGT_W-1:0] row_raw;
      logic [COL_W-1:0] column;
      logic             chan_odd;
   } stage_type;

   // Configuration registers
   logic [MODE_W-1:0]   mode_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [COLOR_W-1:0]  even_color_ff;
   logic [COLOR_W-1:0]  odd_color_ff;

   // Pipeline
   logic                s1_valid_ff, s1_valid_in;
   stage_type           s1_ff, s1_in;
   logic [ROW_W-1:0]    prev_row_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]    rsp_column_ff;
   logic                rsp_span_ff;
   logic [ROW_W-1:0]    rsp_low_ff, rsp_high_ff;
   logic [COLOR_W-1:0]  rsp_color_ff;

   logic                advance, accept;
   logic [HCMP_W-1:0]   height_ext;
   logic [HGT_W-1:0]    height;
   logic [HGT_W-1:0]    top, centre, two_centre;
   logic [SAMPLE_W-1:0] sample;
   logic [SAMPLE_W:0]   offset;
   logic [PROD_W-1:0]   product;
   logic [HGT_W-1:0]    row, prev, low, high, mirror_top;
   logic                span;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_RESET;
         height_ff     <= HEIGHT_RESET;
         even_color_ff <= EVEN_COLOR_RESET;
         odd_color_ff  <= ODD_COLOR_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_DRAW_MODE:  mode_ff       <= csr_wdata[MODE_W-1:0];
            CSR_HEIGHT:     height_ff     <= csr_wdata[HEIGHT_W-1:0];
            CSR_EVEN_COLOR: even_color_ff <= csr_wdata[COLOR_W-1:0];
            CSR_ODD_COLOR:  odd_color_ff  <= csr_wdata[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   // Limit the height to the usable range
   assign height_ext = HCMP_W'(height_ff);
   always_comb begin
      if (height_ext < HCMP_W'(MIN_HEIGHT)) begin
         height = HGT_W'(MIN_HEIGHT);
      end else if (height_ext > HCMP_W'(MAX_HEIGHT)) begin
         height = HGT_W'(MAX_HEIGHT);
      end else begin
         height = HGT_W'(height_ext);
      end
   end
   assign top        = height - HGT_W'(1);
   assign centre     = height >> 1;
   assign two_centre = centre << 1;

   // Handshake: advance when the result register is free or being drained
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   // Scale the sample: (32768 - s) * H, keep the whole rows
   assign sample  = req_tdata[SAMPLE_W-1:0];
   assign offset  = (SAMPLE_W + 1)'(FULL_SCALE) - {sample[SAMPLE_W-1], sample};
   assign product = PROD_W'(offset) * PROD_W'(height);

   always_comb begin
      s1_in.row_raw  = product[SAMPLE_W +: HGT_W];
      s1_in.column   = req_tdata[SAMPLE_W +: COL_W];
      s1_in.chan_odd = req_tuser[0];
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // Input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // Clamp the row and pick the span for the draw mode
   always_comb begin
      row  = (s1_ff.row_raw > top) ? top : s1_ff.row_raw;
      prev = (s1_ff.column == '0) ? row : HGT_W'(prev_row_ff);
      mirror_top = two_centre - row;
      span = 1'b1;
      low  = '0;
      high = '0;
      case (mode_ff)
         MODE_LINE: begin
            if (prev < row) begin
               low  = prev + HGT_W'(1);
               high = row;
            end else if (prev > row) begin
               low  = row;
               high = prev - HGT_W'(1);
            end else begin
               low  = row;
               high = row;
            end
            // a previous row left over from a taller display
            if (high > top) begin
               high = top;
            end
         end
         MODE_MIRROR: begin
            if (row > centre) begin
               low  = mirror_top;
               high = row - HGT_W'(1);
            end else if (row < centre) begin
               low  = row + HGT_W'(1);
               high = (mirror_top > top) ? top : mirror_top;
            end else begin
               low  = centre;
               high = centre;
            end
         end
         MODE_CENTRE: begin
            if (row > centre) begin
               low  = centre;
               high = row - HGT_W'(1);
            end else if (row < centre) begin
               low  = row + HGT_W'(1);
               high = centre;
            end else begin
               low  = centre;
               high = centre;
            end
         end
         default: begin
            // fill to bottom; nothing to paint on the bottom row itself
            if (row == '0) begin
               span = 1'b0;
            end else begin
               high = row - HGT_W'(1);
            end
         end
      endcase
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   end

   // Result stage and previous row
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         prev_row_ff  <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance && s1_valid_ff) begin
            prev_row_ff <= ROW_W'(row);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_column_ff <= s1_ff.column;
         rsp_span_ff   <= span;
         rsp_low_ff    <= ROW_W'(low);
         rsp_high_ff   <= ROW_W'(high);
         rsp_color_ff  <= s1_ff.chan_odd ? odd_color_ff : even_color_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_span_ff;
   assign rsp_tdata  = RSP_DW'({rsp_color_ff, rsp_high_ff, rsp_low_ff, rsp_column_ff});

   // Checks
   `WCSR_ASSERT_SAME(a_empty_span_zero, clock, reset, rsp_valid_ff && !rsp_span_ff,
      rsp_low_ff == '0 && rsp_high_ff == '0, "empty span with nonzero rows")
   `WCSR_ASSERT_SAME(a_span_ordered, clock, reset, rsp_valid_ff && rsp_span_ff,
      rsp_low_ff <= rsp_high_ff, "span low row above high row")
   `WCSR_ASSERT_NEXT(a_stalled_word_kept, clock, reset, s1_valid_ff && !advance,
      s1_valid_ff, "input stage word dropped while result stalled")

endmodule

// ===== bench/tb_waveform_column_span_renderer_unit.sv =====
// Self-checking bench for the waveform column span renderer: drives sample words,
// predicts each span word and checks it field by field. Depends on wcsr_pkg and
// the renderer top level only.
module tb_waveform_column_span_renderer_unit;
   import wcsr_pkg::*;

   localparam int ROW_W       = $clog2(MAX_HEIGHT_DEFAULT);
   localparam int COL_W       = $clog2(MAX_WIDTH_DEFAULT);
   localparam int REQ_DW      = ((SAMPLE_W + COL_W + 7) / 8) * 8;
   localparam int RSP_DW      = ((COL_W + 2 * ROW_W + COLOR_W + 7) / 8) * 8;
   localparam int QUIET_LIMIT = 2000;
   localparam int SAMPLE_GOAL = 1800;

   typedef struct packed {
      logic [COL_W-1:0]   column;
      logic               span_valid;
      logic [ROW_W-1:0]   row_low;
      logic [ROW_W-1:0]   row_high;
      logic [COLOR_W-1:0] color;
   } span_word_type;

   typedef enum int {DRAIN_FREE, DRAIN_CHOPPY, DRAIN_SLUGGISH} drain_style_type;

   // Shadow registers, previous row and the queue of spans still due
   class span_scoreboard;
      logic [MODE_W-1:0]   mode_q;
      logic [HEIGHT_W-1:0] height_q;
      logic [COLOR_W-1:0]  even_q;
      logic [COLOR_W-1:0]  odd_q;
      logic [ROW_W-1:0]    last_row;
      span_word_type       due_spans[$];
      int                  errors;

      function new();
         mode_q   = MODE_RESET;
         height_q = HEIGHT_RESET;
         even_q   = EVEN_COLOR_RESET;
         odd_q    = ODD_COLOR_RESET;
         last_row = '0;
         errors   = 0;
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
         case (addr)
            CSR_DRAW_MODE:  mode_q   = data[MODE_W-1:0];
            CSR_HEIGHT:     height_q = data[HEIGHT_W-1:0];
            CSR_EVEN_COLOR: even_q   = data[COLOR_W-1:0];
            CSR_ODD_COLOR:  odd_q    = data[COLOR_W-1:0];
            default: ;
         endcase
      endfunction

      // Work out the span for one accepted sample word and queue it
      function void note_sample(logic signed [SAMPLE_W-1:0] smp, logic [CHAN_W-1:0] ch,
                                logic [COL_W-1:0] col);
         int h, c, top, v, p, lo, hi;
         logic on;
         span_word_type w;
         h = height_q;
         if (h < MIN_HEIGHT) h = MIN_HEIGHT;
         if (h > MAX_HEIGHT_DEFAULT) h = MAX_HEIGHT_DEFAULT;
         c   = h / 2;
         top = h - 1;
         v   = ((FULL_SCALE - int'(smp)) * h) >> 16;
         if (v > top) v = top;
         on = 1'b1;
         lo = 0;
         hi = 0;
         case (mode_q)
            MODE_LINE: begin
               // column zero restarts the line at the new row
               p = (col == '0) ? v : int'(last_row);
               if (p < v) begin
                  lo = p + 1;
                  hi = v;
               end else if (p > v) begin
                  lo = v;
                  hi = p - 1;
               end else begin
                  lo = v;
                  hi = v;
               end
               // a previous row left over from a taller display
               if (hi > top) hi = top;
            end
            MODE_MIRROR: begin
               if (v > c) begin
                  lo = 2 * c - v;
                  hi = v - 1;
               end else if (v < c) begin
                  lo = v + 1;
                  hi = 2 * c - v;
                  if (hi > top) hi = top;
               end else begin
                  lo = c;
                  hi = c;
               end
            end
            MODE_CENTRE: begin
               if (v > c) begin
                  lo = c;
                  hi = v - 1;
               end else if (v < c) begin
                  lo = v + 1;
                  hi = c;
               end else begin
                  lo = c;
                  hi = c;
               end
            end
            default: begin
               // fill to bottom: nothing to paint when the sample sits on the bottom row
               if (v == 0) on = 1'b0;
               else hi = v - 1;
            end
         endcase
         last_row     = v[ROW_W-1:0];
         w.column     = col;
         w.span_valid = on;
         w.row_low    = lo[ROW_W-1:0];
         w.row_high   = hi[ROW_W-1:0];
         w.color      = ch[0] ? odd_q : even_q;
         due_spans.push_back(w);
      endfunction

      // Compare one span word with the oldest one due
      function void check_span(span_word_type got);
         span_word_type want;
         if (due_spans.size() == 0) begin
            $error("span word for column %0d arrived with nothing due", got.column);
            errors++;
            return;
         end
         want = due_spans.pop_front();
         if (got.column !== want.column) begin
            $error("out_column: expected %0d, got %0d", want.column, got.column);
            errors++;
         end
         if (got.span_valid !== want.span_valid) begin
            $error("span_valid: expected %0d, got %0d", want.span_valid, got.span_valid);
            errors++;
         end
         if (got.row_low !== want.row_low) begin
            $error("row_low: expected %0d, got %0d", want.row_low, got.row_low);
            errors++;
         end
         if (got.row_high !== want.row_high) begin
            $error("row_high: expected %0d, got %0d", want.row_high, got.row_high);
            errors++;
         end
         if (got.color !== want.color) begin
            $error("pixel_color: expected %06h, got %06h", want.color, got.color);
            errors++;
         end
      endfunction

      function int pending();
         return due_spans.size();
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DW-1:0]      req_tdata  = '0;  // sample, column
   logic [CHAN_W-1:0]      req_tuser  = '0;  // channel
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DW-1:0]      rsp_tdata;        // out_column, row_low, row_high, pixel_color
   logic                   rsp_tuser;        // span_valid
   logic                   csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   span_scoreboard  book = new();
   span_word_type   seen_span;
   int              burst_left   = 0;
   int              samples_sent = 0;
   int              quiet_cycles = 0;
   drain_style_type drain_style  = DRAIN_FREE;
   int              drain_left   = 0;

   waveform_column_span_renderer_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Track register writes, check span words, predict from sample words
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) book.write_reg(csr_addr, csr_wdata);
         if (rsp_tvalid && rsp_tready) begin
            seen_span.column     = rsp_tdata[COL_W-1:0];
            seen_span.span_valid = rsp_tuser;
            seen_span.row_low    = rsp_tdata[COL_W +: ROW_W];
            seen_span.row_high   = rsp_tdata[COL_W + ROW_W +: ROW_W];
            seen_span.color      = rsp_tdata[COL_W + 2 * ROW_W +: COLOR_W];
            book.check_span(seen_span);
         end
         if (req_tvalid && req_tready)
            book.note_sample(req_tdata[SAMPLE_W-1:0], req_tuser,
                             req_tdata[SAMPLE_W +: COL_W]);
      end
   end

   // Stall the result side in stretches of its own: free, choppy, sluggish
   always @(posedge clock) begin
      if (!reset) begin
         if (drain_left == 0) begin
            drain_style <= drain_style_type'($urandom_range(0, 2));
            drain_left  <= int'($urandom_range(20, 200));
         end else begin
            drain_left <= drain_left - 1;
         end
         case (drain_style)
            DRAIN_FREE:     rsp_tready <= 1'b1;
            DRAIN_CHOPPY:   rsp_tready <= 1'($urandom_range(0, 1));
            DRAIN_SLUGGISH: rsp_tready <= ($urandom_range(0, 5) == 0);
            default:        rsp_tready <= 1'b1;
         endcase
      end
   end

   // End the run when no word moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one sample word, in bursts with random gaps between them
   task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic [CHAN_W-1:0] ch,
                              input logic [COL_W-1:0] col);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = int'($urandom_range(1, 48));
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DW - SAMPLE_W - COL_W){1'b0}}, col, smp};
      req_tuser  <= ch;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      samples_sent++;
   endtask

   // Drop valid and hold until every span word is back and the pipe is empty;
   // wait for the next edge first so the last accepted word is already noted
   task automatic drain_spans();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (book.pending() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all four registers, one per cycle
   task automatic program_regs(input logic [CSR_DATA_W-1:0] mode_w,
                               input logic [CSR_DATA_W-1:0] height_w,
                               input logic [CSR_DATA_W-1:0] even_w,
                               input logic [CSR_DATA_W-1:0] odd_w);
      logic [CSR_DATA_W-1:0] vals[4];
      vals[CSR_DRAW_MODE]  = mode_w;
      vals[CSR_HEIGHT]     = height_w;
      vals[CSR_EVEN_COLOR] = even_w;
      vals[CSR_ODD_COLOR]  = odd_w;
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= i[CSR_ADDR_W-1:0];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // One trace: mostly a column sweep with a wandering sample, with noise,
   // restarts and broken sweeps mixed in
   task automatic run_trace(input int n);
      int               level;
      int               pick;
      logic [COL_W-1:0] col;
      logic [CHAN_W-1:0] ch;
      level = int'($urandom_range(0, 65535)) - 32768;
      col   = '0;
      ch    = CHAN_W'($urandom_range(0, 7));
      repeat (n) begin
         pick = int'($urandom_range(0, 99));
         if (pick < 8) begin
            send_sample(SAMPLE_W'($urandom), CHAN_W'($urandom), COL_W'($urandom));
         end else begin
            if (pick < 11) col = COL_W'($urandom);
            else if (pick < 13) col = '0;
            if (pick < 18) level = int'($urandom_range(0, 65535)) - 32768;
            else level = level + int'($urandom_range(0, 2048)) - 1024;
            if (level > 32767) level = 32767;
            if (level < -32768) level = -32768;
            if (pick >= 96) level = pick[0] ? 32767 : -32768;
            if (pick == 20) ch = CHAN_W'($urandom_range(0, 7));
            send_sample(level[SAMPLE_W-1:0], ch, col);
            col = col + 1'b1;
         end
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] mode_w, height_w, even_w, odd_w;
      int hsel;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: line mode, full-scale extremes, every channel
      send_sample(16'h8000, 3'd0, 12'd0);
      send_sample(16'h7FFF, 3'd1, 12'd1);
      send_sample(16'h0000, 3'd2, 12'd2);
      send_sample(16'hFFFF, 3'd3, 12'd3);
      send_sample(16'h0001, 3'd4, 12'd4);
      send_sample(16'h0001, 3'd5, 12'd5);
      send_sample(16'h8000, 3'd7, 12'hFFF);
      send_sample(16'h4000, 3'd6, 12'd0);
      drain_spans();

      // Mirror on the tallest display, black and white
      program_regs(CSR_DATA_W'(MODE_MIRROR), 24'd1024, 24'h000000, 24'hFFFFFF);
      send_sample(16'h8000, 3'd0, 12'd10);
      send_sample(16'h7FFF, 3'd1, 12'd11);
      send_sample(16'h0000, 3'd2, 12'd12);
      send_sample(16'hC000, 3'd3, 12'd13);
      drain_spans();

      // Bottom fill with a height below the minimum: empty span on the bottom row
      program_regs(CSR_DATA_W'(MODE_BOTTOM), 24'd0, 24'h123456, 24'hABCDEF);
      send_sample(16'h7FFF, 3'd0, 12'd20);
      send_sample(16'h8000, 3'd1, 12'd21);
      send_sample(16'h0000, 3'd2, 12'd22);
      drain_spans();

      // Centre fill on an odd height
      program_regs(CSR_DATA_W'(MODE_CENTRE), 24'd3, 24'h00FF00, 24'hFF00FF);
      send_sample(16'h0000, 3'd0, 12'd30);
      send_sample(16'h7FFF, 3'd1, 12'd31);
      send_sample(16'h8000, 3'd2, 12'd32);
      drain_spans();

      // Stale previous row: draw high on a tall display, then shrink it
      program_regs(CSR_DATA_W'(MODE_LINE), 24'd1024, 24'hFF0000, 24'h0000FF);
      send_sample(16'h8000, 3'd0, 12'd5);
      drain_spans();
      program_regs(CSR_DATA_W'(MODE_LINE), 24'd1, 24'hFF0000, 24'h0000FF);
      send_sample(16'h0000, 3'd1, 12'd6);
      drain_spans();
      program_regs(CSR_DATA_W'(MODE_LINE), 24'd2047, 24'hFF0000, 24'h0000FF);
      send_sample(16'h8000, 3'd2, 12'd7);

      // Random settings, each followed by a batch of traces
      while (samples_sent < SAMPLE_GOAL) begin
         drain_spans();
         mode_w        = CSR_DATA_W'($urandom);
         mode_w[MODE_W-1:0] = MODE_W'($urandom_range(0, 3));
         height_w      = CSR_DATA_W'($urandom);
         hsel          = int'($urandom_range(0, 9));
         case (hsel)
            0:       height_w[HEIGHT_W-1:0] = HEIGHT_W'($urandom_range(0, 1));
            1:       height_w[HEIGHT_W-1:0] = 11'd2;
            2:       height_w[HEIGHT_W-1:0] = 11'd3;
            3:       height_w[HEIGHT_W-1:0] = 11'd1024;
            4:       height_w[HEIGHT_W-1:0] = HEIGHT_W'($urandom_range(1025, 2047));
            default: height_w[HEIGHT_W-1:0] = HEIGHT_W'($urandom_range(2, 1024));
         endcase
         even_w = ($urandom_range(0, 4) == 0) ? 24'h000000 : CSR_DATA_W'($urandom);
         odd_w  = ($urandom_range(0, 4) == 0) ? 24'hFFFFFF : CSR_DATA_W'($urandom);
         program_regs(mode_w, height_w, even_w, odd_w);
         run_trace(int'($urandom_range(30, 150)));
      end

      drain_spans();
      repeat (8) @(posedge clock);
      if (book.errors == 0 && book.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
